>>> src/bcet_pkg.sv
`default_nettype none

package bcet_pkg;

  localparam int PIX_W         = 24;
  localparam int DIM_W         = 13;
  localparam int COORD_BITS    = 12;
  localparam int FRACTION_BITS = 16;
  localparam int NORM_W        = 16;
  localparam int STEP_W        = $clog2(PIX_W + 1);
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [COORD_BITS-1:0] COORD_MAX    = {COORD_BITS{1'b1}};
  localparam logic [NORM_W-1:0]     NORM_SAT     = NORM_W'((64'd1 << FRACTION_BITS) - 64'd1);
  localparam logic [STEP_W-1:0]     STEPS_SPLIT  = STEP_W'(PIX_W);
  localparam logic [STEP_W-1:0]     STEPS_FRAC   = STEP_W'(FRACTION_BITS);
  localparam logic [DIM_W-1:0]      WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0]      HEIGHT_RESET = DIM_W'(480);

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_NX,
    ST_NY,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_index;
    logic             last_corner;
  } in_t;

  typedef struct packed {
    logic [NORM_W-1:0]     norm_x;
    logic [NORM_W-1:0]     norm_y;
    logic [COORD_BITS-1:0] box_min_x;
    logic [COORD_BITS-1:0] box_max_x;
    logic [COORD_BITS-1:0] box_min_y;
    logic [COORD_BITS-1:0] box_max_y;
    logic [PIX_W-1:0]      min_x_pixel;
    logic [PIX_W-1:0]      max_x_pixel;
    logic [PIX_W-1:0]      min_y_pixel;
    logic [PIX_W-1:0]      max_y_pixel;
    logic                  blob_done;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [DIM_W-1:0]  rem_init;
    logic [PIX_W-1:0]  dividend;
    logic [DIM_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quo;
    logic [DIM_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> src/bcet_div.sv
`default_nettype none

module bcet_div import bcet_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DIM_W-1:0]  rem_r, rem_nxt;
  logic [PIX_W-1:0]  quo_r, quo_nxt;
  logic [DIM_W-1:0]  div_r, div_nxt;
  logic [DIM_W:0]    shifted;
  logic [DIM_W+1:0]  diff;

  always_comb begin
    shifted  = {rem_r, quo_r[PIX_W-1]};
    diff     = {1'b0, shifted} - {2'b00, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = req.rem_init;
      quo_nxt  = req.dividend;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - STEP_W'(1);
      if (!diff[DIM_W+1]) begin
        rem_nxt = diff[DIM_W-1:0];
        quo_nxt = {quo_r[PIX_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIM_W-1:0];
        quo_nxt = {quo_r[PIX_W-2:0], 1'b0};
      end
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

>>> src/blob_corner_extent_tracker.sv
`default_nettype none

// Tracks the bounding box of one blob from its corner pixel indexes, one transaction per
// corner, and reports each corner's column and row as Q0.16 fractions of the image width
// and height. All three divisions run on a single restoring divider that produces one
// quotient bit per clock: first it splits the index into row and column, then it forms
// the horizontal fraction and, unless the row lies outside the image and the vertical
// fraction saturates, the vertical fraction. The input is not ready while a corner is
// being worked on; a finished result waits in the output register. The user must write
// image width and height over the APB port only while the block is idle; the block itself
// does not enforce this. A value of zero acts as one.

module blob_corner_extent_tracker import bcet_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic      [DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  state_t                state_r, state_nxt;
  div_req_t              req_r, req_nxt;
  div_rsp_t              div_rsp;
  logic [DIM_W-1:0]      width_r, height_r;
  logic [DIM_W-1:0]      w_eff, h_eff;
  logic                  cfg_wr;
  logic [PIX_W-1:0]      pix_r, pix_nxt;
  logic                  last_r, last_nxt;
  logic [PIX_W-1:0]      row_r, row_nxt;
  logic [DIM_W-1:0]      col_r, col_nxt;
  logic [NORM_W-1:0]     nx_r, nx_nxt;
  logic [NORM_W-1:0]     ny_r, ny_nxt;
  logic                  have_first_r, have_first_nxt;
  logic [COORD_BITS-1:0] min_x_r, min_x_nxt, max_x_r, max_x_nxt;
  logic [COORD_BITS-1:0] min_y_r, min_y_nxt, max_y_r, max_y_nxt;
  logic [PIX_W-1:0]      min_x_pix_r, min_x_pix_nxt, max_x_pix_r, max_x_pix_nxt;
  logic [PIX_W-1:0]      min_y_pix_r, min_y_pix_nxt, max_y_pix_r, max_y_pix_nxt;
  logic [COORD_BITS-1:0] cx, cy;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_r, out_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_IMAGE_WIDTH:  cfg_prdata = DATA_W'(width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = DATA_W'(height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign w_eff = (width_r == '0) ? DIM_W'(1) : width_r;
  assign h_eff = (height_r == '0) ? DIM_W'(1) : height_r;

  bcet_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (div_rsp)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cx = (col_r > DIM_W'(COORD_MAX)) ? COORD_MAX : col_r[COORD_BITS-1:0];
  assign cy = (row_r > PIX_W'(COORD_MAX)) ? COORD_MAX : row_r[COORD_BITS-1:0];

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    req_nxt.start  = 1'b0;
    pix_nxt        = pix_r;
    last_nxt       = last_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    nx_nxt         = nx_r;
    ny_nxt         = ny_r;
    have_first_nxt = have_first_r;
    min_x_nxt      = min_x_r;
    max_x_nxt      = max_x_r;
    min_y_nxt      = min_y_r;
    max_y_nxt      = max_y_r;
    min_x_pix_nxt  = min_x_pix_r;
    max_x_pix_nxt  = max_x_pix_r;
    min_y_pix_nxt  = min_y_pix_r;
    max_y_pix_nxt  = max_y_pix_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pix_nxt          = in_data.pixel_index;
          last_nxt         = in_data.last_corner;
          req_nxt.start    = 1'b1;
          req_nxt.rem_init = '0;
          req_nxt.dividend = in_data.pixel_index;
          req_nxt.divisor  = w_eff;
          req_nxt.steps    = STEPS_SPLIT;
          state_nxt        = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (div_rsp.done) begin
          row_nxt          = div_rsp.quo;
          col_nxt          = div_rsp.rem;
          req_nxt.start    = 1'b1;
          req_nxt.rem_init = div_rsp.rem;
          req_nxt.dividend = '0;
          req_nxt.divisor  = w_eff;
          req_nxt.steps    = STEPS_FRAC;
          state_nxt        = ST_NX;
        end
      end
      ST_NX: begin
        if (div_rsp.done) begin
          nx_nxt = div_rsp.quo[NORM_W-1:0];
          if (row_r >= PIX_W'(h_eff)) begin
            ny_nxt    = NORM_SAT;
            state_nxt = ST_UPD;
          end else begin
            req_nxt.start    = 1'b1;
            req_nxt.rem_init = row_r[DIM_W-1:0];
            req_nxt.dividend = '0;
            req_nxt.divisor  = h_eff;
            req_nxt.steps    = STEPS_FRAC;
            state_nxt        = ST_NY;
          end
        end
      end
      ST_NY: begin
        if (div_rsp.done) begin
          ny_nxt    = div_rsp.quo[NORM_W-1:0];
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (!out_valid_r || out_ready) begin
          if (!have_first_r) begin
            min_x_nxt     = cx;
            max_x_nxt     = cx;
            min_y_nxt     = cy;
            max_y_nxt     = cy;
            min_x_pix_nxt = pix_r;
            max_x_pix_nxt = pix_r;
            min_y_pix_nxt = pix_r;
            max_y_pix_nxt = pix_r;
          end else begin
            if (cx < min_x_r) begin
              min_x_nxt     = cx;
              min_x_pix_nxt = pix_r;
            end
            if (cx > max_x_r) begin
              max_x_nxt     = cx;
              max_x_pix_nxt = pix_r;
            end
            if (cy < min_y_r) begin
              min_y_nxt     = cy;
              min_y_pix_nxt = pix_r;
            end
            if (cy > max_y_r) begin
              max_y_nxt     = cy;
              max_y_pix_nxt = pix_r;
            end
          end
          have_first_nxt      = !last_r;
          out_nxt.norm_x      = nx_r;
          out_nxt.norm_y      = ny_r;
          out_nxt.box_min_x   = min_x_nxt;
          out_nxt.box_max_x   = max_x_nxt;
          out_nxt.box_min_y   = min_y_nxt;
          out_nxt.box_max_y   = max_y_nxt;
          out_nxt.min_x_pixel = min_x_pix_nxt;
          out_nxt.max_x_pixel = max_x_pix_nxt;
          out_nxt.min_y_pixel = min_y_pix_nxt;
          out_nxt.max_y_pixel = max_y_pix_nxt;
          out_nxt.blob_done   = last_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      req_r.start  <= 1'b0;
      have_first_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      req_r.start  <= req_nxt.start;
      have_first_r <= have_first_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    req_r.rem_init <= req_nxt.rem_init;
    req_r.dividend <= req_nxt.dividend;
    req_r.divisor  <= req_nxt.divisor;
    req_r.steps    <= req_nxt.steps;
    pix_r          <= pix_nxt;
    last_r         <= last_nxt;
    row_r          <= row_nxt;
    col_r          <= col_nxt;
    nx_r           <= nx_nxt;
    ny_r           <= ny_nxt;
    min_x_r        <= min_x_nxt;
    max_x_r        <= max_x_nxt;
    min_y_r        <= min_y_nxt;
    max_y_r        <= max_y_nxt;
    min_x_pix_r    <= min_x_pix_nxt;
    max_x_pix_r    <= max_x_pix_nxt;
    min_y_pix_r    <= min_y_pix_nxt;
    max_y_pix_r    <= max_y_pix_nxt;
    out_r          <= out_nxt;
  end

`ifndef SYNTHESIS
  // Once a corner is taken, the input stays closed while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready straight after an accepted transaction");

  // A reported box never has its least extent above its greatest.
  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.box_min_x <= out_data.box_max_x &&
                   out_data.box_min_y <= out_data.box_max_y))
    else $error("bounding box extents out of order");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_SPLIT || state_r == ST_NX || state_r == ST_NY))
    else $error("divider finished outside a division state");

  // A new result is loaded only when the output register is free or being emptied.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("pending result lost");
`endif

endmodule

`default_nettype wire

>>> verif/blob_corner_extent_tracker_tb.sv
`timescale 1ns / 1ps

module blob_corner_extent_tracker_tb;
  import bcet_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 900;
  localparam int SETTLE_TICKS = 80;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  blob_corner_extent_tracker uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  in_t  corner_queue[$];
  out_t pending_boxes[$];
  out_t next_box;

  int   mismatches = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_rx = 1'b0;

  logic [DIM_W-1:0]      img_w = WIDTH_RESET;
  logic [DIM_W-1:0]      img_h = HEIGHT_RESET;
  logic                  box_open = 1'b0;
  logic [COORD_BITS-1:0] lo_col = '0;
  logic [COORD_BITS-1:0] hi_col = '0;
  logic [COORD_BITS-1:0] lo_row = '0;
  logic [COORD_BITS-1:0] hi_row = '0;
  logic [PIX_W-1:0]      lo_col_pix = '0;
  logic [PIX_W-1:0]      hi_col_pix = '0;
  logic [PIX_W-1:0]      lo_row_pix = '0;
  logic [PIX_W-1:0]      hi_row_pix = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Updates the running bounding box with one corner and returns the result it causes.
  function automatic out_t track_corner(in_t c);
    logic [63:0] w;
    logic [63:0] h;
    logic [63:0] col;
    logic [63:0] row;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    out_t r;
    w   = (img_w == '0) ? 64'd1 : 64'(img_w);
    h   = (img_h == '0) ? 64'd1 : 64'(img_h);
    col = 64'(c.pixel_index) % w;
    row = 64'(c.pixel_index) / w;
    cx  = (col > 64'(COORD_MAX)) ? COORD_MAX : col[COORD_BITS-1:0];
    cy  = (row > 64'(COORD_MAX)) ? COORD_MAX : row[COORD_BITS-1:0];
    r.norm_x = NORM_W'((col << FRACTION_BITS) / w);
    r.norm_y = (row >= h) ? NORM_SAT : NORM_W'((row << FRACTION_BITS) / h);
    if (!box_open) begin
      lo_col = cx;
      hi_col = cx;
      lo_row = cy;
      hi_row = cy;
      lo_col_pix = c.pixel_index;
      hi_col_pix = c.pixel_index;
      lo_row_pix = c.pixel_index;
      hi_row_pix = c.pixel_index;
      box_open = 1'b1;
    end else begin
      if (cx < lo_col) begin
        lo_col = cx;
        lo_col_pix = c.pixel_index;
      end
      if (cx > hi_col) begin
        hi_col = cx;
        hi_col_pix = c.pixel_index;
      end
      if (cy < lo_row) begin
        lo_row = cy;
        lo_row_pix = c.pixel_index;
      end
      if (cy > hi_row) begin
        hi_row = cy;
        hi_row_pix = c.pixel_index;
      end
    end
    r.box_min_x   = lo_col;
    r.box_max_x   = hi_col;
    r.box_min_y   = lo_row;
    r.box_max_y   = hi_row;
    r.min_x_pixel = lo_col_pix;
    r.max_x_pixel = hi_col_pix;
    r.min_y_pixel = lo_row_pix;
    r.max_y_pixel = hi_row_pix;
    r.blob_done   = c.last_corner;
    if (c.last_corner) begin
      box_open = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  task automatic compare_field(string name, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        pending_boxes = {pending_boxes, track_corner(in_data)};
      end
      if (corner_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= corner_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_boxes.size() == 0) begin
          report_mismatch("transaction with no expected result");
        end else begin
          next_box = pending_boxes.pop_front();
          compare_field("norm_x", PIX_W'(out_data.norm_x), PIX_W'(next_box.norm_x));
          compare_field("norm_y", PIX_W'(out_data.norm_y), PIX_W'(next_box.norm_y));
          compare_field("box_min_x", PIX_W'(out_data.box_min_x), PIX_W'(next_box.box_min_x));
          compare_field("box_max_x", PIX_W'(out_data.box_max_x), PIX_W'(next_box.box_max_x));
          compare_field("box_min_y", PIX_W'(out_data.box_min_y), PIX_W'(next_box.box_min_y));
          compare_field("box_max_y", PIX_W'(out_data.box_max_y), PIX_W'(next_box.box_max_y));
          compare_field("min_x_pixel", out_data.min_x_pixel, next_box.min_x_pixel);
          compare_field("max_x_pixel", out_data.max_x_pixel, next_box.max_x_pixel);
          compare_field("min_y_pixel", out_data.min_y_pixel, next_box.min_y_pixel);
          compare_field("max_y_pixel", out_data.max_y_pixel, next_box.max_y_pixel);
          compare_field("blob_done", PIX_W'(out_data.blob_done), PIX_W'(next_box.blob_done));
        end
      end
      out_ready <= !hold_rx && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(logic idx, logic [DIM_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {19'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) begin
      img_w = value;
    end else begin
      img_h = value;
    end
  endtask

  task automatic configure(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (corner_queue.size() != 0 || in_valid || pending_boxes.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic add_corner(logic [PIX_W-1:0] pix, logic last);
    in_t c;
    c.pixel_index = pix;
    c.last_corner = last;
    corner_queue = {corner_queue, c};
  endtask

  // Blobs of random length: mostly corners inside the image, with repeated corners and
  // neighbours in the same column to exercise ties, and some indexes anywhere in range.
  task automatic add_blobs(int count);
    int made;
    int len;
    int pick;
    logic [63:0] we;
    logic [63:0] he;
    logic [63:0] pix;
    logic [63:0] prev;
    made = 0;
    we = (img_w == '0) ? 64'd1 : 64'(img_w);
    he = (img_h == '0) ? 64'd1 : 64'(img_h);
    while (made < count) begin
      len = $urandom_range(1, 8);
      prev = 64'($urandom) & 64'hFFFFFF;
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          pix = 64'($urandom_range(int'(he) - 1)) * we + 64'($urandom_range(int'(we) - 1));
        end else if (pick < 72 && i != 0) begin
          pix = prev;
        end else if (pick < 84 && i != 0) begin
          pix = ($urandom_range(1)) ? prev + we : prev - we;
        end else begin
          pix = 64'($urandom);
        end
        if (pix > 64'hFFFFFF) begin
          pix = 64'($urandom) & 64'hFFFFFF;
        end
        add_corner(PIX_W'(pix), i == len - 1);
        prev = pix;
      end
      made += len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct <= 0;
    stall_pct <= 0;
    add_corner(24'd0, 1'b0);
    add_corner(24'd639, 1'b0);
    add_corner(24'd306560, 1'b0);
    add_corner(24'd307199, 1'b0);
    add_corner(24'hFFFFFF, 1'b0);
    add_corner(24'd0, 1'b0);
    add_corner(24'd639, 1'b1);
    add_corner(24'd5, 1'b1);
    add_corner(24'd307200, 1'b0);
    add_corner(24'd307199, 1'b0);
    add_corner(24'd1280, 1'b1);
    wait_drained();

    configure(13'd0, 13'd0);
    send_idle_pct <= 72;
    add_corner(24'd0, 1'b0);
    add_corner(24'hFFFFFF, 1'b0);
    add_corner(24'd12345, 1'b1);
    add_blobs(60);
    wait_drained();

    configure(13'd8191, 13'd8191);
    send_idle_pct <= 0;
    stall_pct <= 72;
    add_corner(24'd8190, 1'b0);
    add_corner(24'd4095, 1'b0);
    add_corner(24'd4096, 1'b0);
    add_corner(24'd8191, 1'b0);
    add_corner(24'hFFFFFF, 1'b1);
    add_blobs(80);
    wait_drained();

    configure(13'd1, 13'd4096);
    send_idle_pct <= 28;
    stall_pct <= 28;
    add_blobs(80);
    wait_drained();

    configure(13'd4096, 13'd1);
    send_idle_pct <= 0;
    stall_pct <= 0;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none
    add_blobs(80);
    wait_drained();

    configure(DIM_W'($urandom_range(1, 4096)), DIM_W'($urandom_range(1, 4096)));
    send_idle_pct <= 28;
    stall_pct <= 28;
    add_blobs(100);
    wait_drained();

    configure(DIM_W'($urandom_range(1, 64)), DIM_W'($urandom_range(1, 4096)));
    send_idle_pct <= 72;
    stall_pct <= 0;
    add_blobs(100);
    wait_drained();

    repeat (SETTLE_TICKS) @(posedge clk);
    if (pending_boxes.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending_boxes.size()));
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
src/bcet_pkg.sv
src/bcet_div.sv
src/blob_corner_extent_tracker.sv
verif/blob_corner_extent_tracker_tb.sv
